// ===== rtl/acc_cpu_pkg.sv =====
// Shared types and constants for the accumulator core.
package acc_cpu_pkg;

  localparam int MEM_BYTES_DEF = 65536;
  localparam logic [15:0] STACK_BASE_RST = 16'(1024 * 32);

  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_STEP    = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_HLT    = 3'd1;
  localparam logic [2:0] ST_BADLRA = 3'd2;
  localparam logic [2:0] ST_BADOP  = 3'd3;
  localparam logic [2:0] ST_DIVZ   = 3'd4;
  localparam logic [2:0] ST_HALTED = 3'd5;

  localparam logic [7:0] OP_HLT = 8'd0;
  localparam logic [7:0] OP_ADD = 8'd4;
  localparam logic [7:0] OP_SUB = 8'd5;
  localparam logic [7:0] OP_MUL = 8'd6;
  localparam logic [7:0] OP_DIV = 8'd7;
  localparam logic [7:0] OP_LTB = 8'd8;
  localparam logic [7:0] OP_BSR = 8'd9;
  localparam logic [7:0] OP_BSL = 8'd10;
  localparam logic [7:0] OP_MOD = 8'd11;
  localparam logic [7:0] OP_BIO = 8'd12;
  localparam logic [7:0] OP_BIA = 8'd13;
  localparam logic [7:0] OP_BIX = 8'd14;
  localparam logic [7:0] OP_BIN = 8'd15;
  localparam logic [7:0] OP_BLO = 8'd16;
  localparam logic [7:0] OP_BLA = 8'd17;
  localparam logic [7:0] OP_BLX = 8'd18;
  localparam logic [7:0] OP_BLN = 8'd19;
  localparam logic [7:0] OP_TEQ = 8'd20;
  localparam logic [7:0] OP_JMP = 8'd21;
  localparam logic [7:0] OP_JEZ = 8'd22;
  localparam logic [7:0] OP_JNZ = 8'd23;
  localparam logic [7:0] OP_LIA = 8'd24;
  localparam logic [7:0] OP_LIB = 8'd25;
  localparam logic [7:0] OP_SWP = 8'd26;
  localparam logic [7:0] OP_LMA = 8'd27;
  localparam logic [7:0] OP_SMA = 8'd28;
  localparam logic [7:0] OP_LRA = 8'd29;
  localparam logic [7:0] OP_POP = 8'd30;
  localparam logic [7:0] OP_PSH = 8'd31;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] load_addr;
    logic [7:0]  load_byte;
  } in_req_t;

  typedef struct packed {
    logic [15:0] reg_a;
    logic [15:0] reg_b;
    logic [15:0] stack_ptr;
    logic [15:0] prog_ctr;
    logic        carry;
    logic        halted;
    logic [2:0]  status;
  } out_res_t;

endpackage

// ===== rtl/acc_cpu_ram.sv =====
// Generic single-port RAM with a registered read.
module acc_cpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/acc_cpu_front.sv =====
// Front end: takes requests and queues them for the execution unit.
module acc_cpu_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  acc_cpu_pkg::in_req_t  in_req,
  output logic                  q_valid,
  output acc_cpu_pkg::in_req_t  q_req,
  input  logic                  q_pop
);
  import acc_cpu_pkg::*;

  // Two-entry queue of requests.
  in_req_t    slot_r [2];
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       rd_r;
  logic       push;

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_req   = slot_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && q_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (q_pop) rd_r <= ~rd_r;
    end
    if (push) begin
      slot_r[rd_r ^ cnt_r[0]] <= in_req;
    end
  end
endmodule

// ===== rtl/acc_cpu_div.sv =====
// Iterative signed 16-bit divider giving truncated quotient and remainder.
module acc_cpu_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quot,
  output logic [15:0] rem
);
  logic [15:0] q_r, d_r;
  logic [16:0] r_r;
  logic [4:0]  cnt_r;
  logic        run_r, nq_r, nr_r;
  logic [16:0] trial;

  assign trial = {r_r[15:0], q_r[15]} - {1'b0, d_r};
  assign quot  = nq_r ? 16'(-q_r) : q_r;
  assign rem   = nr_r ? 16'(-r_r[15:0]) : r_r[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= 5'd16;
        q_r   <= dividend[15] ? 16'(-dividend) : dividend;
        d_r   <= divisor[15] ? 16'(-divisor) : divisor;
        r_r   <= 17'd0;
        nq_r  <= dividend[15] ^ divisor[15];
        nr_r  <= dividend[15];
      end else if (run_r) begin
        if (!trial[16]) begin
          r_r <= trial;
          q_r <= {q_r[14:0], 1'b1};
        end else begin
          r_r <= {r_r[15:0], q_r[15]};
          q_r <= {q_r[14:0], 1'b0};
        end
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          run_r <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/acc_cpu_back.sv =====
// Back end: executes queued requests against the registers and byte memory.
module acc_cpu_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [15:0]            stack_base,
  input  logic                   q_valid,
  input  acc_cpu_pkg::in_req_t   q_req,
  output logic                   q_pop,
  output logic                   out_valid,
  output acc_cpu_pkg::out_res_t  out_res
);
  import acc_cpu_pkg::*;

  localparam int AW = $clog2(MEM_BYTES_DEF);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FETCH = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_MRD   = 4'd3;
  localparam logic [3:0] S_MWR   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [3:0]  st_r;
  logic [15:0] a_r, b_r, sp_r, pc_r;
  logic        c_r, h_r;
  logic [2:0]  stat_r;
  logic [31:0] word_r;
  logic [2:0]  cnt_r;
  logic [15:0] base_r;
  logic [15:0] prod_r;

  logic          we;
  logic [15:0]   addr16;
  logic [7:0]    wdata, rdata;
  logic          div_go, div_done;
  logic [15:0]   quot, rem;
  logic [7:0]    op;
  logic [15:0]   nxt;
  logic [16:0]   sum;
  logic signed [16:0] diff;
  logic [15:0]   shr, shl;

  assign op  = word_r[31:24];
  assign nxt = pc_r + 16'd4;

  acc_cpu_ram #(.WIDTH(8), .DEPTH(MEM_BYTES_DEF)) u_ram (
    .clk(clk), .we(we), .addr(addr16[AW-1:0]), .wdata(wdata), .rdata(rdata)
  );

  acc_cpu_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .dividend(a_r), .divisor(b_r),
    .done(div_done), .quot(quot), .rem(rem)
  );

  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign div_go = (st_r == S_EXEC) && (op == OP_DIV || op == OP_MOD) && (b_r != 16'd0);

  always_comb begin
    sum  = {1'b0, a_r} + {1'b0, b_r};
    diff = $signed({1'b0, a_r}) - $signed({1'b0, b_r});
    shr  = (b_r >= 16'd16) ? {16{a_r[15]}} : 16'($signed(a_r) >>> b_r[3:0]);
    shl  = (b_r >= 16'd16) ? 16'd0 : (a_r << b_r[3:0]);
  end

  // Memory port: byte address and write data for the current state.
  always_comb begin
    we     = 1'b0;
    wdata  = 8'd0;
    addr16 = pc_r + 16'(cnt_r);
    if (st_r == S_IDLE) begin
      addr16 = q_req.load_addr;
      wdata  = q_req.load_byte;
      we     = q_valid && (q_req.req_type == REQ_LOAD);
    end else if (st_r == S_MRD) begin
      addr16 = base_r + 16'(cnt_r[0]);
    end else if (st_r == S_MWR) begin
      addr16 = base_r + 16'(cnt_r[0]);
      wdata  = cnt_r[0] ? a_r[7:0] : a_r[15:8];
      we     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      out_valid <= 1'b0;
      a_r <= 16'd0; b_r <= 16'd0; pc_r <= 16'd0;
      sp_r <= STACK_BASE_RST; c_r <= 1'b0; h_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          cnt_r  <= 3'd0;
          stat_r <= ST_OK;
          if (q_valid) begin
            case (q_req.req_type)
              REQ_STEP: begin
                if (h_r) begin
                  stat_r <= ST_HALTED;
                  st_r   <= S_DONE;
                end else begin
                  st_r <= S_FETCH;
                end
              end
              REQ_RESTART: begin
                a_r <= 16'd0; b_r <= 16'd0; pc_r <= 16'd0;
                c_r <= 1'b0; h_r <= 1'b0; sp_r <= stack_base;
                st_r <= S_DONE;
              end
              default: st_r <= S_DONE;
            endcase
          end
        end
        S_FETCH: begin
          // Read data is registered: byte n arrives at count n+1.
          if (cnt_r != 3'd0) word_r <= {word_r[23:0], rdata};
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd4) st_r <= S_EXEC;
        end
        S_EXEC: begin
          st_r  <= S_DONE;
          cnt_r <= 3'd0;
          pc_r  <= nxt;
          case (op)
            OP_HLT: begin h_r <= 1'b1; stat_r <= ST_HLT; end
            OP_ADD: begin c_r <= (sum > 17'h7FFF); a_r <= sum[15:0]; end
            OP_SUB: begin c_r <= (diff < -17'sh8000); a_r <= diff[15:0]; end
            OP_MUL: begin prod_r <= a_r * b_r; st_r <= S_MUL; end
            OP_DIV, OP_MOD: begin
              if (b_r == 16'd0) begin
                h_r <= 1'b1; stat_r <= ST_DIVZ;
              end else begin
                st_r <= S_DIV;
              end
            end
            OP_LTB: a_r <= {15'd0, $signed(a_r) < $signed(b_r)};
            OP_BSR: a_r <= shr;
            OP_BSL: a_r <= shl;
            OP_BIO: a_r <= a_r | b_r;
            OP_BIA: a_r <= a_r & b_r;
            OP_BIX: a_r <= a_r ^ b_r;
            OP_BIN: a_r <= ~a_r;
            OP_BLO: a_r <= {15'd0, (a_r != 16'd0) || (b_r != 16'd0)};
            OP_BLA: a_r <= {15'd0, (a_r != 16'd0) && (b_r != 16'd0)};
            OP_BLX: a_r <= {15'd0, (a_r != 16'd0) != (b_r != 16'd0)};
            OP_BLN: a_r <= {15'd0, a_r != 16'd0};
            OP_TEQ: a_r <= {15'd0, a_r == b_r};
            OP_JMP: pc_r <= b_r;
            OP_JEZ: pc_r <= (a_r == 16'd0) ? b_r : nxt;
            OP_JNZ: pc_r <= (a_r != 16'd0) ? b_r : nxt;
            OP_LIA: a_r <= word_r[15:0];
            OP_LIB: b_r <= word_r[15:0];
            OP_SWP: begin a_r <= b_r; b_r <= a_r; end
            OP_LMA: begin base_r <= b_r; st_r <= S_MRD; end
            OP_SMA: begin base_r <= b_r; st_r <= S_MWR; end
            OP_LRA: begin
              case (word_r[1:0])
                2'd0: a_r <= sp_r;
                2'd1: a_r <= nxt;
                2'd2: a_r <= {15'd0, c_r};
                default: begin h_r <= 1'b1; stat_r <= ST_BADLRA; end
              endcase
            end
            OP_POP: begin
              base_r <= sp_r - 16'd2; sp_r <= sp_r - 16'd2; st_r <= S_MRD;
            end
            OP_PSH: begin
              base_r <= sp_r; sp_r <= sp_r + 16'd2; st_r <= S_MWR;
            end
            default: begin h_r <= 1'b1; stat_r <= ST_BADOP; pc_r <= pc_r; end
          endcase
        end
        S_MRD: begin
          if (cnt_r != 3'd0) a_r <= {a_r[7:0], rdata};
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd2) st_r <= S_DONE;
        end
        S_MWR: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd1) st_r <= S_DONE;
        end
        S_MUL: begin
          a_r  <= prod_r;
          st_r <= S_DONE;
        end
        S_DIV: begin
          if (div_done) begin
            a_r  <= (op == OP_DIV) ? quot : rem;
            st_r <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          st_r      <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    out_res.reg_a     = a_r;
    out_res.reg_b     = b_r;
    out_res.stack_ptr = sp_r;
    out_res.prog_ctr  = pc_r;
    out_res.carry     = c_r;
    out_res.halted    = h_r;
    out_res.status    = stat_r;
  end
endmodule

// ===== rtl/accumulator_cpu_core.sv =====
// Top level of the accumulator core: request queue, execution unit and config register.
//
// Usage:
//   A request (load byte, step one instruction, restart) is presented on in_req
//   with start high; it is taken at a clock edge where busy is low. Up to two
//   requests wait in a queue in front of the execution unit.
//   Every request produces one result on out_res, marked by out_valid for one
//   cycle; the receiver must take it then.
//   A load, restart or step while halted goes straight to the result; a step
//   fetches four bytes from the byte-wide memory, then executes; a multiply
//   adds a state, a two-byte memory or stack access goes through the single
//   memory port and divide or modulo waits for the bit-serial divider. One
//   request is executed at a time.
//   cfg_we writes cfg_data to the stack base used by the next restart.
//   After reset a, b, pc and flags are zero, sp and the stack base are 32768;
//   memory contents are undefined until loaded.
module accumulator_cpu_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  acc_cpu_pkg::in_req_t  in_req,
  output logic                  out_valid,
  output acc_cpu_pkg::out_res_t out_res,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_data
);
  import acc_cpu_pkg::*;

  logic [15:0] base_r;
  logic        q_valid, q_pop;
  in_req_t     q_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= STACK_BASE_RST;
    end else if (cfg_we) begin
      base_r <= cfg_data;
    end
  end

  acc_cpu_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
  );

  acc_cpu_back u_back (
    .clk(clk), .rst_n(rst_n), .stack_base(base_r), .q_valid(q_valid),
    .q_req(q_req), .q_pop(q_pop), .out_valid(out_valid), .out_res(out_res)
  );
endmodule
